// ===== hdl/lzbd_pkg.sv =====
// Shared constants, types and helpers for the LZ block decompressor.
package lzbd_pkg;

  localparam int unsigned WINDOW_DEPTH = 65536;
  localparam int unsigned HIST_AW      = $clog2(WINDOW_DEPTH);
  localparam int unsigned BW_W         = HIST_AW + 1;

  localparam logic [1:0] TAG_LITERAL = 2'b00;
  localparam logic [1:0] TAG_COPY1   = 2'b01;
  localparam logic [1:0] TAG_COPY2   = 2'b10;
  localparam logic [1:0] TAG_BAD     = 2'b11;

  localparam logic [5:0] LIT_SHORT_MAX = 6'd60;
  localparam logic [5:0] LIT_LEN_BIAS  = 6'd59;
  localparam logic [6:0] COPY1_MIN_LEN = 7'd4;

  typedef struct packed {
    logic               rd_en;
    logic [HIST_AW-1:0] rd_addr;
    logic               wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic [7:0]         wr_data;
  } hist_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    logic       err;
  } res_t;

  function automatic logic [HIST_AW-1:0] ptr_inc(input logic [HIST_AW-1:0] p);
    logic [HIST_AW-1:0] r;
    if (p == HIST_AW'(WINDOW_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

  function automatic logic [BW_W-1:0] count_sat_inc(input logic [BW_W-1:0] c);
    logic [BW_W-1:0] r;
    if (c < BW_W'(WINDOW_DEPTH)) r = c + 1'b1;
    else r = c;
    return r;
  endfunction

endpackage

// ===== hdl/lz_block_decompressor.sv =====
// Top level of the LZ block decompressor: parser, history memory and output register.
// A literal byte or illegal-tag error enters the output register as its request is taken;
// a distance error comes from the offset check. Header, tag, length and literal bytes are
// taken whenever the output register is free; a copy holds the input through the offset
// check and its history reads, paced by the memory's single read and single write port.
// Reset (rst_n low, synchronous) returns the parser to the header and clears the pointers;
// the history memory is not cleared and needs no clearing pass.
module lz_block_decompressor
  import lzbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] stream_first
  input  logic       in_tlast,   // stream_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] format_error
  output logic       out_tlast   // run_last
);

  res_t       res;
  hist_req_t  req;
  logic [7:0] hist_q;
  logic       out_free;

  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_err_r;
  logic       out_last_r;

  // The output register may take a new result when it is empty or being drained.
  assign out_free = !out_valid_r || out_tready;

  lzbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_first (in_tuser),
    .in_last  (in_tlast),
    .out_free (out_free),
    .res      (res),
    .req      (req),
    .hist_q   (hist_q)
  );

  lzbd_hist_ram u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rd_q  (hist_q)
  );

  // Output register: loaded only when the controller issues a result into a free slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.data;
      out_err_r  <= res.err;
      out_last_r <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_last_r;

  // A result must never overwrite one that is still waiting.
  a_res_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> out_free)
    else $error("result issued while the output register was occupied");

  // Input is only taken when a result it causes can be stored.
  a_ready_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> out_free)
    else $error("input ready while the output register cannot accept");

  // History writes accompany good output bytes only.
  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> (res.valid && !res.err))
    else $error("history write without a matching output byte");

  // An error result carries a zero byte and closes the run.
  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.err |=> (out_tdata == 8'd0) && out_tlast)
    else $error("malformed error result");

endmodule

// ===== hdl/lzbd_hist_ram.sv =====
// History memory: one write and one registered read per cycle, with same-address bypass.
module lzbd_hist_ram
  import lzbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  hist_req_t req,
  output logic [7:0] rd_q
);

  logic [7:0] mem [WINDOW_DEPTH];
  logic [7:0] q_r;
  logic [7:0] fwd_data_r;
  logic       fwd_sel_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q_r        <= mem[req.rd_addr];
      fwd_data_r <= req.wr_data;
    end
  end

  // A read of the entry being written this cycle takes the new byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sel_r <= 1'b0;
    end else if (req.rd_en) begin
      fwd_sel_r <= req.wr_en && (req.wr_addr == req.rd_addr);
    end
  end

  assign rd_q = fwd_sel_r ? fwd_data_r : q_r;

endmodule

// ===== hdl/lzbd_ctrl.sv =====
// Stream parser and copy sequencer driving the history memory.
module lzbd_ctrl
  import lzbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_first,
  input  logic       in_last,
  input  logic       out_free,
  output res_t       res,
  output hist_req_t  req,
  input  logic [7:0] hist_q
);

  typedef enum logic [2:0] {
    S_HEADER, S_TAG, S_LITLEN, S_LITERAL, S_OFFSET, S_CHECK, S_COPY
  } state_t;

  state_t             state_r,    state_nxt;
  logic [32:0]        lit_r,      lit_nxt;
  logic [2:0]         fld_r,      fld_nxt;
  logic [7:0]         tag_r,      tag_nxt;
  logic [15:0]        off_r,      off_nxt;
  logic [HIST_AW-1:0] wp_r,       wp_nxt;
  logic [BW_W-1:0]    bw_r,       bw_nxt;
  logic               hold_last_r, hold_last_nxt;
  logic [HIST_AW-1:0] rd_addr_r,  rd_addr_nxt;
  logic [6:0]         rd_left_r,  rd_left_nxt;
  logic [6:0]         em_left_r,  em_left_nxt;
  logic               rd_pend_r,  rd_pend_nxt;

  always_comb begin
    state_t      phase;
    logic        acc;
    logic        can_emit;
    logic        issue;
    logic        finish;
    logic [5:0]  len_code;
    logic [2:0]  total;
    logic [1:0]  idx;
    logic [32:0] lit_or;
    logic [16:0] diff;

    state_nxt     = state_r;
    lit_nxt       = lit_r;
    fld_nxt       = fld_r;
    tag_nxt       = tag_r;
    off_nxt       = off_r;
    wp_nxt        = wp_r;
    bw_nxt        = bw_r;
    hold_last_nxt = hold_last_r;
    rd_addr_nxt   = rd_addr_r;
    rd_left_nxt   = rd_left_r;
    em_left_nxt   = em_left_r;
    rd_pend_nxt   = rd_pend_r;
    res           = '0;
    req           = '0;
    in_ready      = 1'b0;
    acc           = 1'b0;
    can_emit      = 1'b0;
    issue         = 1'b0;
    finish        = 1'b0;
    phase         = state_r;
    len_code      = '0;
    total         = '0;
    idx           = '0;
    lit_or        = '0;
    diff          = '0;

    unique case (state_r)
      S_HEADER, S_TAG, S_LITLEN, S_LITERAL, S_OFFSET: begin
        in_ready = out_free;
        acc      = in_valid && out_free;
        if (acc) begin
          if (in_first) begin
            phase  = S_HEADER;
            wp_nxt = '0;
            bw_nxt = '0;
          end
          unique case (phase)
            S_HEADER: begin
              if (!in_byte[7]) state_nxt = S_TAG;
              else state_nxt = S_HEADER;
            end
            S_TAG: begin
              tag_nxt = in_byte;
              unique case (in_byte[1:0])
                TAG_LITERAL: begin
                  if (in_byte[7:2] < LIT_SHORT_MAX) begin
                    lit_nxt   = 33'(in_byte[7:2]) + 33'd1;
                    state_nxt = S_LITERAL;
                  end else begin
                    len_code  = in_byte[7:2] - LIT_LEN_BIAS;
                    lit_nxt   = '0;
                    fld_nxt   = len_code[2:0];
                    state_nxt = S_LITLEN;
                  end
                end
                TAG_COPY1: begin
                  fld_nxt   = 3'd1;
                  off_nxt   = '0;
                  state_nxt = S_OFFSET;
                end
                TAG_COPY2: begin
                  fld_nxt   = 3'd2;
                  off_nxt   = '0;
                  state_nxt = S_OFFSET;
                end
                TAG_BAD: begin
                  res.valid = 1'b1;
                  res.last  = 1'b1;
                  res.err   = 1'b1;
                end
                default: ;
              endcase
            end
            S_LITLEN: begin
              len_code = tag_r[7:2] - LIT_LEN_BIAS;
              total    = len_code[2:0];
              idx      = 2'(total - fld_r);
              lit_or   = lit_r | (33'(in_byte) << {idx, 3'b000});
              fld_nxt  = fld_r - 3'd1;
              if (fld_r == 3'd1) begin
                lit_nxt   = lit_or + 33'd1;
                state_nxt = S_LITERAL;
              end else begin
                lit_nxt = lit_or;
              end
            end
            S_LITERAL: begin
              res.valid   = 1'b1;
              res.data    = in_byte;
              res.last    = 1'b1;
              req.wr_en   = 1'b1;
              req.wr_addr = wp_r;
              req.wr_data = in_byte;
              wp_nxt      = ptr_inc(wp_r);
              bw_nxt      = count_sat_inc(bw_r);
              lit_nxt     = lit_r - 33'd1;
              if (lit_r == 33'd1) state_nxt = S_TAG;
            end
            S_OFFSET: begin
              if (tag_r[1:0] == TAG_COPY1) begin
                off_nxt     = {5'd0, tag_r[7:5], in_byte};
                em_left_nxt = COPY1_MIN_LEN + 7'(tag_r[4:2]);
                rd_left_nxt = COPY1_MIN_LEN + 7'(tag_r[4:2]);
                state_nxt   = S_CHECK;
              end else if (fld_r == 3'd2) begin
                off_nxt = {8'd0, in_byte};
                fld_nxt = 3'd1;
              end else begin
                off_nxt     = {in_byte, off_r[7:0]};
                em_left_nxt = 7'(tag_r[7:2]) + 7'd1;
                rd_left_nxt = 7'(tag_r[7:2]) + 7'd1;
                fld_nxt     = '0;
                state_nxt   = S_CHECK;
              end
            end
            default: ;
          endcase
          if (state_nxt == S_CHECK) begin
            hold_last_nxt = in_last;
          end else if (in_last) begin
            state_nxt = S_HEADER;
            wp_nxt    = '0;
            bw_nxt    = '0;
          end
        end
      end
      S_CHECK: begin
        if (out_free) begin
          if (off_r == 16'd0 || 17'(off_r) > 17'(bw_r)) begin
            res.valid = 1'b1;
            res.last  = 1'b1;
            res.err   = 1'b1;
            finish    = 1'b1;
          end else begin
            diff = 17'(wp_r) - 17'(off_r);
            if (17'(wp_r) < 17'(off_r)) diff = diff + 17'(WINDOW_DEPTH);
            rd_addr_nxt = HIST_AW'(diff);
            rd_pend_nxt = 1'b0;
            state_nxt   = S_COPY;
          end
        end
      end
      S_COPY: begin
        can_emit = rd_pend_r && out_free;
        issue    = (rd_left_r != 7'd0) && (!rd_pend_r || can_emit);
        if (can_emit) begin
          res.valid   = 1'b1;
          res.data    = hist_q;
          res.last    = (em_left_r == 7'd1);
          req.wr_en   = 1'b1;
          req.wr_addr = wp_r;
          req.wr_data = hist_q;
          wp_nxt      = ptr_inc(wp_r);
          bw_nxt      = count_sat_inc(bw_r);
          em_left_nxt = em_left_r - 7'd1;
          if (em_left_r == 7'd1) finish = 1'b1;
        end
        if (issue) begin
          req.rd_en   = 1'b1;
          req.rd_addr = rd_addr_r;
          rd_addr_nxt = ptr_inc(rd_addr_r);
          rd_left_nxt = rd_left_r - 7'd1;
          rd_pend_nxt = 1'b1;
        end else if (can_emit) begin
          rd_pend_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    if (finish) begin
      if (hold_last_r) begin
        state_nxt = S_HEADER;
        wp_nxt    = '0;
        bw_nxt    = '0;
      end else begin
        state_nxt = S_TAG;
      end
      hold_last_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_HEADER;
      lit_r       <= '0;
      fld_r       <= '0;
      tag_r       <= '0;
      off_r       <= '0;
      wp_r        <= '0;
      bw_r        <= '0;
      hold_last_r <= 1'b0;
      rd_addr_r   <= '0;
      rd_left_r   <= '0;
      em_left_r   <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lit_r       <= lit_nxt;
      fld_r       <= fld_nxt;
      tag_r       <= tag_nxt;
      off_r       <= off_nxt;
      wp_r        <= wp_nxt;
      bw_r        <= bw_nxt;
      hold_last_r <= hold_last_nxt;
      rd_addr_r   <= rd_addr_nxt;
      rd_left_r   <= rd_left_nxt;
      em_left_r   <= em_left_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the LZ block decompressor, with a built-in decoder model.
`timescale 1ns / 100ps

module tb
  import lzbd_pkg::*;
();

  // The run is cut short here if the block stops making progress.
  localparam int unsigned CYCLE_LIMIT = 1000000;

  // Parser phases of the decoder model.
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_TAG,
    PH_LITLEN,
    PH_LITERAL,
    PH_OFFSET
  } dec_phase_t;

  // One decompressed byte as the block should present it.
  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       fmt_err;
  } out_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tuser = 1'b0;    // [0] stream_first
  logic       in_tlast = 1'b0;    // stream_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tuser;          // [0] format_error
  logic       out_tlast;          // run_last

  // State of the decoder model.
  dec_phase_t         dec_phase;
  logic [32:0]        lit_left;
  logic [2:0]         len_bytes_left;
  logic [7:0]         held_tag;
  logic [15:0]        off_acc;
  logic [7:0]         hist_mem [0:WINDOW_DEPTH-1];
  logic [HIST_AW-1:0] wr_ptr;
  logic [BW_W-1:0]    wr_count;

  // Bytes still owed by the block, oldest first.
  out_beat_t pending_out_bytes [$];
  out_beat_t want_beat;

  // Bytes of the element that the random generator is about to send.
  logic [7:0] elem_q [$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned rx_gap = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;

  always #4 clk = ~clk;

  lz_block_decompressor DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // Decoder model. It is run on each request at the moment the request is
  // offered; the block cannot answer before it accepts, so the expectations
  // are always in place in time.
  // ---------------------------------------------------------------------------

  // Returns the parser to the header and forgets the window of the stream.
  task automatic restart_decoder();
    dec_phase      = PH_HEADER;
    lit_left       = '0;
    len_bytes_left = '0;
    held_tag       = '0;
    off_acc        = '0;
    wr_ptr         = '0;
    wr_count       = '0;
  endtask

  // A produced byte is both owed to the output and written into the window.
  task automatic emit_out_byte(input logic [7:0] b);
    pending_out_bytes.push_back('{value: b, run_last: 1'b0, fmt_err: 1'b0});
    hist_mem[wr_ptr] = b;
    wr_ptr = (wr_ptr == HIST_AW'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    if (wr_count < BW_W'(WINDOW_DEPTH)) wr_count = wr_count + 1'b1;
  endtask

  task automatic push_error_beat();
    pending_out_bytes.push_back('{value: 8'h00, run_last: 1'b0, fmt_err: 1'b1});
  endtask

  // A copy walks forward from the given distance back. Each byte goes into
  // the window before the next one is read, so a distance shorter than the
  // length repeats the most recent bytes.
  task automatic copy_from_history(input logic [16:0] back_off, input int unsigned len);
    logic [HIST_AW-1:0] rd;
    if (back_off == 0 || back_off > wr_count) begin
      push_error_beat();
      return;
    end
    rd = (wr_ptr >= back_off) ? HIST_AW'(wr_ptr - back_off) :
                                HIST_AW'(wr_ptr + WINDOW_DEPTH - back_off);
    repeat (len) begin
      emit_out_byte(hist_mem[rd]);
      rd = (rd == HIST_AW'(WINDOW_DEPTH - 1)) ? '0 : rd + 1'b1;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic is_first, input logic is_last);
    int unsigned n_before;
    logic [2:0]  total;
    logic [1:0]  idx;
    logic [16:0] back_off;
    out_beat_t   tail;
    n_before = pending_out_bytes.size();
    if (is_first) restart_decoder();
    case (dec_phase)
      PH_HEADER: begin
        // Varint bytes with the top bit set keep the header going.
        if (!b[7]) dec_phase = PH_TAG;
      end
      PH_TAG: begin
        held_tag = b;
        case (b[1:0])
          TAG_LITERAL: begin
            if (b[7:2] < LIT_SHORT_MAX) begin
              lit_left  = 33'(b[7:2]) + 33'd1;
              dec_phase = PH_LITERAL;
            end else begin
              lit_left       = '0;
              len_bytes_left = 3'(b[7:2] - LIT_LEN_BIAS);
              dec_phase      = PH_LITLEN;
            end
          end
          TAG_COPY1: begin
            len_bytes_left = 3'd1;
            off_acc        = '0;
            dec_phase      = PH_OFFSET;
          end
          TAG_COPY2: begin
            len_bytes_left = 3'd2;
            off_acc        = '0;
            dec_phase      = PH_OFFSET;
          end
          default: push_error_beat();
        endcase
      end
      PH_LITLEN: begin
        // The length field is little-endian, lowest byte first.
        total          = 3'(held_tag[7:2] - LIT_LEN_BIAS);
        idx            = 2'(total - len_bytes_left);
        lit_left       = lit_left | (33'(b) << (8 * idx));
        len_bytes_left = len_bytes_left - 3'd1;
        if (len_bytes_left == 3'd0) begin
          lit_left  = lit_left + 33'd1;
          dec_phase = PH_LITERAL;
        end
      end
      PH_LITERAL: begin
        emit_out_byte(b);
        lit_left = lit_left - 33'd1;
        if (lit_left == '0) dec_phase = PH_TAG;
      end
      default: begin
        if (held_tag[1:0] == TAG_COPY1) begin
          back_off = {6'd0, held_tag[7:5], b};
          copy_from_history(back_off, 32'(COPY1_MIN_LEN) + held_tag[4:2]);
          dec_phase = PH_TAG;
        end else if (len_bytes_left == 3'd2) begin
          off_acc        = {8'h00, b};
          len_bytes_left = 3'd1;
        end else begin
          back_off = {1'b0, b, off_acc[7:0]};
          off_acc  = back_off[15:0];
          copy_from_history(back_off, 1 + held_tag[7:2]);
          len_bytes_left = 3'd0;
          dec_phase      = PH_TAG;
        end
      end
    endcase
    // The final byte caused by this request carries the run marker.
    if (pending_out_bytes.size() > n_before) begin
      tail = pending_out_bytes.pop_back();
      tail.run_last = 1'b1;
      pending_out_bytes.push_back(tail);
    end
    if (is_last) restart_decoder();
  endtask

  // ---------------------------------------------------------------------------
  // Request side. A random hold-off may come before a request; tvalid is only
  // lowered there, so a back-to-back request never sees it dropped and raised
  // again within one time step.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    decode_byte(b, is_first, is_last);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= is_first;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side. The ready line stalls in random bursts while idling is on.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_gap != 0) begin
      rx_gap     <= rx_gap - 1;
      out_tready <= (rx_gap == 1);
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      rx_gap     <= $urandom_range(1, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Every accepted result is matched against the oldest outstanding one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_out_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h run_last %0b format_error %0b",
               out_tdata, out_tlast, out_tuser);
        error_count++;
      end else begin
        want_beat = pending_out_bytes.pop_front();
        if (out_tdata !== want_beat.value) begin
          $error("out_byte: expected %02h, actual %02h", want_beat.value, out_tdata);
          error_count++;
        end
        if (out_tlast !== want_beat.run_last) begin
          $error("run_last: expected %0b, actual %0b", want_beat.run_last, out_tlast);
          error_count++;
        end
        if (out_tuser !== want_beat.fmt_err) begin
          $error("format_error: expected %0b, actual %0b", want_beat.fmt_err, out_tuser);
          error_count++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests.
  // ---------------------------------------------------------------------------

  // Opens a stream with a three-byte header, then the short literal form and
  // the long form with four length bytes.
  task automatic test_literals();
    send_byte(8'h85, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFC, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'hF0, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b0);
  endtask

  // Both copy forms: a one-byte overlap, the longest short copy reaching back
  // to the start of the window, and the longest long copy, which also ends
  // the stream.
  task automatic test_copies();
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h1D, 1'b0, 1'b0);
    send_byte(8'h08, 1'b0, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b0);
    send_byte(8'h03, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
  endtask

  // The illegal tag, a zero distance, and distances past the written bytes
  // for both copy forms; parsing must carry on after each of them.
  task automatic test_errors();
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h11, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);
    send_byte(8'h02, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hE1, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
  endtask

  // A new stream starting in the middle of a literal, and a stream that ends
  // with a literal cut short.
  task automatic test_stream_control();
    send_byte(8'h08, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b0);
    send_byte(8'h80, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h04, 1'b0, 1'b0);
    send_byte(8'h44, 1'b0, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Random streams.
  // ---------------------------------------------------------------------------

  // Builds one element. Most are well formed, with copy distances inside the
  // bytes written so far; a few are deliberate errors and a few are noise.
  task automatic build_element();
    int unsigned pick, len, nb, back_off, reach;
    elem_q.delete();
    pick  = $urandom_range(0, 99);
    reach = (wr_count > 65535) ? 65535 : wr_count;
    if (pick < 35) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 8);
      elem_q.push_back({6'(len - 1), TAG_LITERAL});
      repeat (len) elem_q.push_back(8'($urandom));
    end else if (pick < 45) begin
      nb  = $urandom_range(1, 4);
      len = $urandom_range(1, 16);
      elem_q.push_back({6'(LIT_LEN_BIAS + nb), TAG_LITERAL});
      elem_q.push_back(8'(len - 1));
      repeat (nb - 1) elem_q.push_back(8'h00);
      repeat (len) elem_q.push_back(8'($urandom));
    end else if (pick < 65) begin
      len      = $urandom_range(4, 11);
      back_off = (reach == 0) ? 1 : $urandom_range(1, (reach > 2047) ? 2047 : reach);
      elem_q.push_back({3'(back_off >> 8), 3'(len - 4), TAG_COPY1});
      elem_q.push_back(8'(back_off));
    end else if (pick < 90) begin
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
      back_off = (reach == 0) ? 1 : $urandom_range(1, reach);
      elem_q.push_back({6'(len - 1), TAG_COPY2});
      elem_q.push_back(8'(back_off));
      elem_q.push_back(8'(back_off >> 8));
    end else if (pick < 95) begin
      case ($urandom_range(0, 2))
        0: begin
          elem_q.push_back({6'($urandom), TAG_BAD});
        end
        1: begin
          back_off = ($urandom_range(0, 1) == 0 || reach >= 2047) ? 0 :
                     $urandom_range(reach + 1, 2047);
          elem_q.push_back({3'(back_off >> 8), 3'($urandom), TAG_COPY1});
          elem_q.push_back(8'(back_off));
        end
        default: begin
          back_off = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(reach + 1, 65535);
          elem_q.push_back({6'($urandom), TAG_COPY2});
          elem_q.push_back(8'(back_off));
          elem_q.push_back(8'(back_off >> 8));
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 3)) elem_q.push_back(8'($urandom));
    end
  endtask

  // Streams of header and elements until enough requests have gone out. Most
  // streams end on the last byte of an element; some are abandoned and the
  // next one starts with the first marker. The final third runs without any
  // idling on either side.
  task automatic test_random_streams(input int unsigned n_bytes);
    int unsigned start, n_hdr, n_elem;
    logic [7:0]  hdr_b;
    bit          ends, closed, fin, prev_ended;
    start      = bytes_sent;
    prev_ended = 1'b1;
    while (bytes_sent - start < n_bytes) begin
      if (bytes_sent - start > n_bytes * 2 / 3) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      n_hdr = $urandom_range(1, 3);
      for (int i = 0; i < n_hdr; i++) begin
        hdr_b    = 8'($urandom);
        hdr_b[7] = (i != n_hdr - 1);
        send_byte(hdr_b, (i == 0) && (!prev_ended || $urandom_range(0, 7) != 0), 1'b0);
      end
      n_elem = $urandom_range(1, 8);
      ends   = ($urandom_range(0, 5) != 0);
      closed = 1'b0;
      for (int e = 0; e < n_elem; e++) begin
        build_element();
        for (int i = 0; i < elem_q.size(); i++) begin
          fin = ends && (e == n_elem - 1) && (i == elem_q.size() - 1);
          send_byte(elem_q[i], 1'b0, fin);
          closed = fin;
        end
        // Noise can leave the parser inside an element of unknown size; the
        // stream is then closed rather than fed further.
        if (dec_phase != PH_TAG) break;
      end
      if (ends && !closed) send_byte(8'($urandom), 1'b0, 1'b1);
      prev_ended = ends;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------
  initial begin
    restart_decoder();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_literals();
    test_copies();
    test_errors();
    test_stream_control();
    test_random_streams(80);
    in_tvalid <= 1'b0;
    while (pending_out_bytes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
